// File: hdl/asas_pkg.sv
// Package for the ADC scan averaging sequencer.
// Holds the item types, mode and register codes and the default sizes.
// No dependencies.
package asas_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int AVG_ROUNDS_DEF = 64;
  localparam int STORE_DEPTH    = 8;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [1:0] MODE_CONVERT      = 2'd0;
  localparam logic [1:0] MODE_READ_LATEST  = 2'd1;
  localparam logic [1:0] MODE_READ_AVERAGE = 2'd2;
  localparam logic [1:0] MODE_RESERVED     = 2'd3;

  localparam logic REG_REFERENCE_SELECT = 1'b0;
  localparam logic REG_SKIP_SHARED      = 1'b1;

  localparam logic [1:0] REFERENCE_RESET = 2'd1;
  localparam logic       SKIP_RESET      = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] sample;
    logic [2:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [9:0] latest_value;
    logic [7:0] average_value;
    logic [2:0] next_channel;
    logic [7:0] mux_select;
    logic       averages_updated;
  } out_item_t;

  typedef struct packed {
    logic [1:0] reference_select;
    logic       skip_shared_channels;
  } cfg_t;

endpackage

// File: hdl/asas_cfg_regs.sv
// Configuration registers behind the APB-style port.
// Depends on asas_pkg.
module asas_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [asas_pkg::ADDR_W-1:0] paddr,
  input  logic [asas_pkg::DATA_W-1:0] pwdata,
  output logic [asas_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output asas_pkg::cfg_t             cfg
);
  import asas_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_REFERENCE_SELECT: cfg_nxt.reference_select = pwdata[1:0];
        REG_SKIP_SHARED:      cfg_nxt.skip_shared_channels = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REFERENCE_SELECT: prdata = {{(DATA_W-2){1'b0}}, cfg_r.reference_select};
      REG_SKIP_SHARED:      prdata = {{(DATA_W-1){1'b0}}, cfg_r.skip_shared_channels};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reference_select     <= REFERENCE_RESET;
      cfg_r.skip_shared_channels <= SKIP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/asas_in_stage.sv
// Input register stage: holds one accepted item until the core takes it.
// Depends on asas_pkg.
module asas_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  asas_pkg::in_item_t  in_data,
  input  logic                take,
  output logic                s1_valid,
  output asas_pkg::in_item_t  s1_item
);
  import asas_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;
  logic     accept;

  assign in_stall = valid_r & ~take;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt = 1'b1;
      item_nxt  = in_data;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: hdl/asas_scan_core.sv
// Scan state, per-channel stores, single-pass update and result register.
// Depends on asas_pkg.
module asas_scan_core #(
  parameter int CHANNELS   = asas_pkg::CHANNELS_DEF,
  parameter int AVG_ROUNDS = asas_pkg::AVG_ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  asas_pkg::cfg_t      cfg,
  input  logic                s1_valid,
  input  asas_pkg::in_item_t  s1_item,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output asas_pkg::out_item_t out_data
);
  import asas_pkg::*;

  localparam int RND_W = $clog2(AVG_ROUNDS + 1);

  logic [2:0]       cur_r, cur_nxt;
  logic [RND_W-1:0] round_r, round_nxt;
  logic [9:0]       latest_r [STORE_DEPTH];
  logic [15:0]      acc_r    [STORE_DEPTH];
  logic [7:0]       avg_r    [STORE_DEPTH];

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, res;

  logic             convert;
  logic [3:0]       step;
  logic             wrapped;
  logic [2:0]       chan_next;
  logic [15:0]      acc_sum;
  logic [RND_W-1:0] round_inc;
  logic             finish;

  assign take    = s1_valid & (~out_valid_r | ~out_stall);
  assign convert = (s1_item.mode == MODE_CONVERT);

  always_comb begin
    step = {1'b0, cur_r} + 4'd1;
    if (cfg.skip_shared_channels && (step == 4'd4 || step == 4'd5)) begin
      step = 4'd6;
    end
  end

  assign wrapped   = (step >= 4'(CHANNELS)) || (step > 4'd7);
  assign chan_next = wrapped ? 3'd0 : step[2:0];
  assign acc_sum   = acc_r[cur_r] + 16'(s1_item.sample);
  assign round_inc = round_r + RND_W'(1);
  assign finish    = wrapped && (round_inc >= RND_W'(AVG_ROUNDS));

  always_comb begin
    res                  = '0;
    res.next_channel     = cur_r;
    case (s1_item.mode)
      MODE_CONVERT: begin
        res.next_channel     = chan_next;
        res.averages_updated = finish;
      end
      MODE_READ_LATEST:  res.latest_value  = latest_r[s1_item.channel];
      MODE_READ_AVERAGE: res.average_value = avg_r[s1_item.channel];
      default:           res.averages_updated = 1'b0;
    endcase
    res.mux_select = {cfg.reference_select, 3'b000, res.next_channel};
  end

  always_comb begin
    cur_nxt   = cur_r;
    round_nxt = round_r;
    if (take && convert) begin
      cur_nxt = chan_next;
      if (wrapped) begin
        round_nxt = finish ? '0 : round_inc;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stores reset to zero as the scan reads them before every channel is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        latest_r[i] <= '0;
        acc_r[i]    <= '0;
        avg_r[i]    <= '0;
      end
    end else if (take && convert) begin
      latest_r[cur_r] <= s1_item.sample;
      if (finish) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          avg_r[i] <= (3'(i) == cur_r) ? acc_sum[15:8] : acc_r[i][15:8];
          acc_r[i] <= '0;
        end
      end else begin
        acc_r[cur_r] <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/adc_scan_average_sequencer_top.sv
// Top level of the ADC scan averaging sequencer.
// Depends on asas_pkg, asas_cfg_regs, asas_in_stage and asas_scan_core.
//
// Takes one item per clock cycle while in_stall is low and returns exactly
// one result per item, in order. An accepted item is held in the input
// register, then the scan core updates channel state and loads the result
// register once that register is empty or being taken by the receiver.
// The input register takes a new item while a result is held by out_stall;
// the input side stalls only once both registers are occupied.
// Configuration writes belong to idle periods.
module adc_scan_average_sequencer_top #(
  parameter int CHANNELS   = asas_pkg::CHANNELS_DEF,
  parameter int AVG_ROUNDS = asas_pkg::AVG_ROUNDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  asas_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output asas_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asas_pkg::ADDR_W-1:0] paddr,
  input  logic [asas_pkg::DATA_W-1:0] pwdata,
  output logic [asas_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import asas_pkg::*;

  cfg_t     cfg;
  logic     s1_valid;
  in_item_t s1_item;
  logic     take;

  asas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asas_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  asas_scan_core #(
    .CHANNELS   (CHANNELS),
    .AVG_ROUNDS (AVG_ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_update_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.averages_updated |-> out_data.next_channel == 3'd0)
    else $error("averaging period ended without channel wrap");

  a_one_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.latest_value == 10'd0 || out_data.average_value == 8'd0))
    else $error("result carries both latest and average values");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a held input item");

endmodule

// File: bench/tb_adc_scan_average_sequencer_top.sv
// Self-checking bench for adc_scan_average_sequencer_top: directed and random transfers,
// a scoreboard with a cycle-free scan/averaging predictor, and APB writes between phases.
// Depends on asas_pkg and the sequencer RTL only.
module tb_adc_scan_average_sequencer_top;
  import asas_pkg::*;

  localparam int PHASE_ITEMS = 295;
  localparam logic [9:0] PHASE_REF  = {2'd0, 2'd1, 2'd2, 2'd0, 2'd3};
  localparam logic [4:0] PHASE_SKIP = 5'b01010;
  localparam int HOLD_CYCLES = 60;

  class scan_scoreboard;
    logic [1:0]  refsel;
    logic        skip_shared;
    logic [2:0]  cur_chan;
    logic [9:0]  latest [8];
    logic [15:0] acc [8];
    logic [7:0]  avg [8];
    logic [6:0]  rounds;
    out_item_t   pending [$];
    int          errors;
    int          accepted;
    int          checked;
    int          periods;
    int          reg_writes;

    function new();
      refsel = REFERENCE_RESET;
      skip_shared = SKIP_RESET;
      cur_chan = '0;
      rounds = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        latest[i] = '0;
        acc[i] = '0;
        avg[i] = '0;
      end
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      reg_writes++;
      case (idx)
        REG_REFERENCE_SELECT: refsel = value[1:0];
        REG_SKIP_SHARED: skip_shared = value[0];
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t  r;
      logic [3:0] nxt;
      logic       wrapped;
      r = '0;
      accepted++;
      case (it.mode)
        MODE_CONVERT: begin
          latest[cur_chan] = it.sample;
          acc[cur_chan] = acc[cur_chan] + 16'(it.sample);
          nxt = 4'(cur_chan) + 4'd1;
          if (skip_shared && (nxt == 4'd4 || nxt == 4'd5)) nxt = 4'd6;
          wrapped = (int'(nxt) >= CHANNELS_DEF) || (nxt > 4'd7);
          if (wrapped) nxt = 4'd0;
          cur_chan = nxt[2:0];
          if (wrapped) begin
            rounds = rounds + 7'd1;
            if (int'(rounds) >= AVG_ROUNDS_DEF) begin
              for (int i = 0; i < STORE_DEPTH; i++) begin
                avg[i] = acc[i][15:8];
                acc[i] = '0;
              end
              rounds = '0;
              periods++;
              r.averages_updated = 1'b1;
            end
          end
        end
        MODE_READ_LATEST: r.latest_value = latest[it.channel];
        MODE_READ_AVERAGE: r.average_value = avg[it.channel];
        default: ;
      endcase
      r.next_channel = cur_chan;
      r.mux_select = {refsel, 3'b000, cur_chan};
      pending.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("latest_value", 16'(want.latest_value), 16'(got.latest_value));
      compare_field("average_value", 16'(want.average_value), 16'(got.average_value));
      compare_field("next_channel", 16'(want.next_channel), 16'(got.next_channel));
      compare_field("mux_select", 16'(want.mux_select), 16'(got.mux_select));
      compare_field("averages_updated", 16'(want.averages_updated),
                    16'(got.averages_updated));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                calm = 1'b0;
  logic                hold_req = 1'b0;
  logic                hold_seen = 1'b0;
  int                  hold_left = 0;
  scan_scoreboard      sb = new();

  adc_scan_average_sequencer_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic in_item_t make_item(logic [1:0] mode, logic [9:0] sample,
                                         logic [2:0] channel);
    in_item_t it;
    it.mode = mode;
    it.sample = sample;
    it.channel = channel;
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("adc_scan_average_sequencer_top: mismatch");
    $finish;
  end

  initial begin
    in_item_t    it;
    int          pick;
    logic [1:0]  mode;
    logic [9:0]  sample;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: reference 1, channels 4 and 5 skipped
    offer(make_item(MODE_READ_AVERAGE, 10'd0, 3'd0));
    offer(make_item(MODE_READ_LATEST, 10'd0, 3'd7));
    offer(make_item(MODE_RESERVED, 10'h3FF, 3'd7));
    offer(make_item(MODE_CONVERT, 10'h3FF, 3'd0));
    offer(make_item(MODE_CONVERT, 10'h000, 3'd7));
    offer(make_item(MODE_CONVERT, 10'h2AA, 3'd5));
    offer(make_item(MODE_CONVERT, 10'h155, 3'd2));
    offer(make_item(MODE_CONVERT, 10'h3FF, 3'd4));
    offer(make_item(MODE_CONVERT, 10'h200, 3'd1));
    offer(make_item(MODE_READ_LATEST, 10'h3FF, 3'd0));
    offer(make_item(MODE_READ_LATEST, 10'd0, 3'd4));
    offer(make_item(MODE_READ_LATEST, 10'd0, 3'd3));
    offer(make_item(MODE_READ_AVERAGE, 10'd0, 3'd7));
    offer(make_item(MODE_RESERVED, 10'd0, 3'd0));
    drain();

    // widest reference, no skipping: channels 4 and 5 get scanned
    write_reg(REG_REFERENCE_SELECT, 32'd3);
    write_reg(REG_SKIP_SHARED, 32'd0);
    for (int c = 0; c < 8; c++) offer(make_item(MODE_CONVERT, 10'h3FF - 10'(c), 3'(c)));
    offer(make_item(MODE_READ_LATEST, 10'd0, 3'd5));
    offer(make_item(MODE_READ_LATEST, 10'd0, 3'd4));
    offer(make_item(MODE_READ_AVERAGE, 10'd0, 3'd5));

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_reg(REG_REFERENCE_SELECT, 32'(PHASE_REF[2*p +: 2]));
        write_reg(REG_SKIP_SHARED, 32'(PHASE_SKIP[p]));
      end
      calm = (p == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 150) drain();
        if (p == 2 && n == 100) hold_req = !hold_req;
        pick = $urandom_range(0, 99);
        if (pick < 82) mode = MODE_CONVERT;
        else if (pick < 91) mode = MODE_READ_LATEST;
        else if (pick < 98) mode = MODE_READ_AVERAGE;
        else mode = MODE_RESERVED;
        pick = $urandom_range(0, 99);
        if (pick < 15) sample = 10'h3FF;
        else if (pick < 20) sample = 10'h000;
        else sample = 10'($urandom_range(0, 1023));
        it = make_item(mode, sample, 3'($urandom_range(0, 7)));
        offer(it);
      end
    end
    drain();

    $display("Covered %0d transfers, %0d results checked, %0d averaging periods,",
             sb.accepted, sb.checked, sb.periods);
    $display("%0d register writes across reference and skip settings, %0d errors",
             sb.reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("adc_scan_average_sequencer_top: match");
    end else begin
      $display("adc_scan_average_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
